[hdl/slsi_pkg.sv]
package slsi_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int NLVL     = IDX_W;
  localparam int LVL_W    = $clog2(NLVL + 1);

  localparam int FUNC_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
  localparam int                FN_SEARCH_BIT = 1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic apply;
    logic search;
    logic append;
  } cell_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } pfx_ctrl_t;

endpackage

[hdl/slsi_if.sv]
interface slsi_in_if import slsi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  value_t              value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface slsi_out_if import slsi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, position, entry_count, input ready);
  modport sink   (input valid, status, position, entry_count, output ready);
endinterface

[hdl/sorted_list_insert_search.sv]
// Channel   Dir  Payload                              Transfer
// in_ch     in   func[1:0], value[31:0] signed        valid && ready
// out_ch    out  status[1:0], position[7:0],          valid && ready
//                entry_count[8:0]
//
// Per item, the key is compared in every cell as the item is taken, the prefix
// OR is built across the cell row in S_SCAN, and in S_APPLY the row is shifted
// and the result registered. A new item is taken once the previous one has
// reached the output register. Reset empties the list at once; entries are left
// as they are. A stalled output holds the row in S_APPLY until taken.
module sorted_list_insert_search import slsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  slsi_in_if.sink     in_ch,
  slsi_out_if.source  out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  value_t              key_r;
  logic [FUNC_W-1:0]   func_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [POS_W-1:0]    position_r;
  logic [COUNT_W-1:0]  entry_count_r;

  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] pre;
  logic [CAPACITY-1:0] first;
  value_t              entry [CAPACITY];
  logic                pfx_last;
  pfx_ctrl_t           pfx_ctrl;
  cell_ctrl_t          cell_ctrl;
  value_t              key_bus;
  logic                in_xfer;
  logic                can_out;
  logic                is_search;
  logic                full;
  logic                do_insert;
  logic [IDX_W-1:0]    enc_pos;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign can_out     = !out_valid_r || out_ch.ready;
  assign is_search   = func_r[FN_SEARCH_BIT];
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign do_insert   = (state_r == S_APPLY) && can_out && !is_search && !full;

  assign key_bus          = (state_r == S_IDLE) ? in_ch.value : key_r;
  assign cell_ctrl.apply  = do_insert;
  assign cell_ctrl.search = in_ch.func[FN_SEARCH_BIT];
  assign cell_ctrl.append = (in_ch.func == FN_APPEND);

  assign pfx_ctrl.load = in_xfer;
  assign pfx_ctrl.step = (state_r == S_SCAN);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_entry;
    logic   pre_left;

    if (i == 0) begin : g_head
      assign left_entry = key_r;
      assign pre_left   = 1'b0;
    end else begin : g_body
      assign left_entry = entry[i-1];
      assign pre_left   = pre[i-1];
    end

    assign first[i] = pre[i] && !pre_left;

    slsi_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .key        (key_bus),
      .occ        (CNT_W'(i) < count_r),
      .at_tail    (CNT_W'(i) == count_r),
      .left_entry (left_entry),
      .pre_self   (pre[i]),
      .pre_left   (pre_left),
      .entry      (entry[i]),
      .hit        (hit[i])
    );
  end

  slsi_prefix u_prefix (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (pfx_ctrl),
    .hit   (hit),
    .pre   (pre),
    .last  (pfx_last)
  );

  // at most one bit of first is set, so an OR of the indices encodes it
  always_comb begin
    enc_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        enc_pos = enc_pos | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_APPLY && can_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            key_r   <= in_ch.value;
            func_r  <= in_ch.func;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pfx_last) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (can_out) begin
            state_r <= S_IDLE;
            priority if (is_search) begin
              status_r      <= pre[CAPACITY-1] ? ST_FOUND : ST_NOTFOUND;
              position_r    <= pre[CAPACITY-1] ? POS_W'(enc_pos) : '0;
              entry_count_r <= COUNT_W'(count_r);
            end else if (full) begin
              status_r      <= ST_FULL;
              position_r    <= '0;
              entry_count_r <= COUNT_W'(count_r);
            end else begin
              status_r      <= ST_INSERTED;
              position_r    <= POS_W'(enc_pos);
              entry_count_r <= COUNT_W'(count_r + CNT_W'(1));
              count_r       <= count_r + CNT_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.position    = position_r;
  assign out_ch.entry_count = entry_count_r;

endmodule

[hdl/slsi_cell.sv]
module slsi_cell import slsi_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  value_t     key,
  input  logic       occ,
  input  logic       at_tail,
  input  value_t     left_entry,
  input  logic       pre_self,
  input  logic       pre_left,
  output value_t     entry,
  output logic       hit
);

  value_t entry_r;

  assign entry = entry_r;

  always_comb begin
    if (ctrl.search) begin
      hit = occ && (entry_r == key);
    end else if (ctrl.append) begin
      hit = at_tail;
    end else begin
      hit = at_tail || (occ && (key < entry_r));
    end
  end

  // first cell of the prefix takes the key, the ones behind it take their left neighbour
  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      if (pre_self && !pre_left) begin
        entry_r <= key;
      end else if (pre_self) begin
        entry_r <= left_entry;
      end
    end
  end

endmodule

[hdl/slsi_prefix.sv]
module slsi_prefix import slsi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  pfx_ctrl_t           ctrl,
  input  logic [CAPACITY-1:0] hit,
  output logic [CAPACITY-1:0] pre,
  output logic                last
);

  logic [CAPACITY-1:0] pre_r;
  logic [LVL_W-1:0]    lvl_r;

  assign pre  = pre_r;
  assign last = (lvl_r == LVL_W'(NLVL - 1));

  // log-step prefix OR: pre[i] ends up as the OR of hit[0..i]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
    end else if (ctrl.load) begin
      pre_r <= hit;
      lvl_r <= '0;
    end else if (ctrl.step) begin
      pre_r <= pre_r | (pre_r << (32'd1 << lvl_r));
      lvl_r <= last ? '0 : lvl_r + LVL_W'(1);
    end
  end

endmodule

[hdl/slsi_chk.sv]
module slsi_chk import slsi_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [POS_W-1:0]    position,
  input logic [COUNT_W-1:0]  entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
      && $stable(entry_count))
    else $error("result changed while stalled");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL || status == ST_NOTFOUND) |-> position == '0)
    else $error("position not zero for dropped insert or missed search");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> entry_count == COUNT_W'(CAPACITY))
    else $error("list reported full below capacity");

  a_ins_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_INSERTED && CAPACITY <= 256
      |-> entry_count != '0 && COUNT_W'(position) < entry_count)
    else $error("insert position beyond list length");

endmodule

bind sorted_list_insert_search slsi_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .position    (out_ch.position),
  .entry_count (out_ch.entry_count)
);
